/* hw/rtl/spq_pkg.sv */
// Shared types and default constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned DepthDef        = 16;
  localparam int unsigned KeyWidthDef     = 16;
  localparam int unsigned PayloadWidthDef = 32;
  localparam int unsigned CountFieldWidth = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } spq_op_e;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic    en;
    spq_op_e op;
  } spq_ctrl_t;

endpackage

/* hw/rtl/spq_if.sv */
// Valid/ready channel interfaces for queue operations and their results.
interface spq_op_if #(
  parameter int unsigned KEY_WIDTH     = 16,
  parameter int unsigned PAYLOAD_WIDTH = 32
);
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [KEY_WIDTH-1:0]     item_key;
  logic [PAYLOAD_WIDTH-1:0] item_payload;

  modport source (output valid, operation, item_key, item_payload, input ready);
  modport sink   (input valid, operation, item_key, item_payload, output ready);
endinterface

interface spq_res_if #(
  parameter int unsigned KEY_WIDTH     = 16,
  parameter int unsigned PAYLOAD_WIDTH = 32
);
  logic                     valid;
  logic                     ready;
  logic                     removed_valid;
  logic [KEY_WIDTH-1:0]     removed_key;
  logic [PAYLOAD_WIDTH-1:0] removed_payload;
  logic                     overflow;
  logic [4:0]               entry_count;
  logic [KEY_WIDTH-1:0]     head_key;
  logic [PAYLOAD_WIDTH-1:0] head_payload;
  logic [KEY_WIDTH-1:0]     tail_key;
  logic [PAYLOAD_WIDTH-1:0] tail_payload;

  modport source (output valid, removed_valid, removed_key, removed_payload, overflow,
                  entry_count, head_key, head_payload, tail_key, tail_payload,
                  input ready);
  modport sink   (input valid, removed_valid, removed_key, removed_payload, overflow,
                  entry_count, head_key, head_payload, tail_key, tail_payload,
                  output ready);
endinterface

/* hw/rtl/spq_cell.sv */
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module spq_cell #(
  parameter int unsigned KEY_WIDTH     = spq_pkg::KeyWidthDef,
  parameter int unsigned PAYLOAD_WIDTH = spq_pkg::PayloadWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  spq_pkg::spq_ctrl_t       ctrl_i,
  input  logic [KEY_WIDTH-1:0]     new_key_i,
  input  logic [PAYLOAD_WIDTH-1:0] new_payload_i,
  input  logic [KEY_WIDTH-1:0]     left_key_i,
  input  logic [PAYLOAD_WIDTH-1:0] left_payload_i,
  input  logic                     left_occ_i,
  input  logic                     left_ge_i,
  input  logic [KEY_WIDTH-1:0]     right_key_i,
  input  logic [PAYLOAD_WIDTH-1:0] right_payload_i,
  input  logic                     right_occ_i,
  output logic [KEY_WIDTH-1:0]     key_o,
  output logic [PAYLOAD_WIDTH-1:0] payload_o,
  output logic                     occ_o,
  output logic                     ge_o
);
  import spq_pkg::*;

  logic [KEY_WIDTH-1:0]     key_q, key_d;
  logic [PAYLOAD_WIDTH-1:0] payload_q, payload_d;
  logic                     occ_q, occ_d;
  logic                     ge;

  // Free slots count as greater, so the insert point is the first set flag.
  assign ge = !occ_q || (key_q >= new_key_i);

  always_comb begin
    key_d     = key_q;
    payload_d = payload_q;
    occ_d     = occ_q;
    if (ctrl_i.en) begin
      case (ctrl_i.op)
        OP_INSERT: begin
          if (ge) begin
            if (left_ge_i) begin
              key_d     = left_key_i;
              payload_d = left_payload_i;
            end else begin
              key_d     = new_key_i;
              payload_d = new_payload_i;
            end
          end
          occ_d = occ_q | left_occ_i;
        end
        OP_REMOVE: begin
          key_d     = right_key_i;
          payload_d = right_payload_i;
          occ_d     = right_occ_i;
        end
        default: begin
          occ_d = occ_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign key_o     = key_q;
  assign payload_o = payload_q;
  assign occ_o     = occ_q;
  assign ge_o      = ge;

endmodule

/* hw/rtl/sorted_priority_queue.sv */
// Output: each transferred operation's result is registered in the output register.
// Throughput: one operation per cycle while the result side takes each result; every cell
// compares and shifts in the same cycle, and the output register is the only buffer.
// Reset: clears every slot's occupied flag, the entry count and the result valid;
// slot contents and result fields are not reset.
module sorted_priority_queue #(
  parameter int unsigned DEPTH         = spq_pkg::DepthDef,
  parameter int unsigned KEY_WIDTH     = spq_pkg::KeyWidthDef,
  parameter int unsigned PAYLOAD_WIDTH = spq_pkg::PayloadWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_op_if.sink    in_i,
  spq_res_if.source out_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [KEY_WIDTH-1:0]     cell_key     [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] cell_payload [DEPTH];
  logic [DEPTH-1:0]         cell_occ;
  logic [DEPTH-1:0]         cell_ge;

  spq_ctrl_t                ctrl;
  spq_op_e                  op;
  logic                     xfer;
  logic                     full, empty;
  logic                     do_insert, do_remove;

  logic [CntW-1:0]          count_q, count_d;
  logic [KEY_WIDTH-1:0]     tail_key_q, tail_key_d;
  logic [PAYLOAD_WIDTH-1:0] tail_payload_q, tail_payload_d;

  logic [KEY_WIDTH-1:0]     head_key_nxt;
  logic [PAYLOAD_WIDTH-1:0] head_payload_nxt;

  logic                     out_valid_q;
  logic                     rm_valid_q;
  logic [KEY_WIDTH-1:0]     rm_key_q;
  logic [PAYLOAD_WIDTH-1:0] rm_payload_q;
  logic                     overflow_q;
  logic [CntW-1:0]          res_count_q;
  logic [KEY_WIDTH-1:0]     head_key_q, tail_key_res_q;
  logic [PAYLOAD_WIDTH-1:0] head_payload_q, tail_payload_res_q;

  assign op        = spq_op_e'(in_i.operation);
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign xfer      = in_i.valid && in_i.ready;
  assign full      = cell_occ[DEPTH-1];
  assign empty     = !cell_occ[0];
  assign do_insert = xfer && (op == OP_INSERT) && !full;
  assign do_remove = xfer && (op == OP_REMOVE) && !empty;

  assign ctrl.en = do_insert || do_remove;
  assign ctrl.op = op;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0]     l_key, r_key;
    logic [PAYLOAD_WIDTH-1:0] l_payload, r_payload;
    logic                     l_occ, l_ge, r_occ;

    if (i == 0) begin : g_first
      // The head has a full, smaller neighbor on its left.
      assign l_key     = in_i.item_key;
      assign l_payload = in_i.item_payload;
      assign l_occ     = 1'b1;
      assign l_ge      = 1'b0;
    end else begin : g_mid
      assign l_key     = cell_key[i-1];
      assign l_payload = cell_payload[i-1];
      assign l_occ     = cell_occ[i-1];
      assign l_ge      = cell_ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_key     = cell_key[i];
      assign r_payload = cell_payload[i];
      assign r_occ     = 1'b0;
    end else begin : g_inner
      assign r_key     = cell_key[i+1];
      assign r_payload = cell_payload[i+1];
      assign r_occ     = cell_occ[i+1];
    end

    spq_cell #(
      .KEY_WIDTH    (KEY_WIDTH),
      .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .new_key_i      (in_i.item_key),
      .new_payload_i  (in_i.item_payload),
      .left_key_i     (l_key),
      .left_payload_i (l_payload),
      .left_occ_i     (l_occ),
      .left_ge_i      (l_ge),
      .right_key_i    (r_key),
      .right_payload_i(r_payload),
      .right_occ_i    (r_occ),
      .key_o          (cell_key[i]),
      .payload_o      (cell_payload[i]),
      .occ_o          (cell_occ[i]),
      .ge_o           (cell_ge[i])
    );
  end

  // Track the tail beside the chain: only an insert above the current maximum, or into an empty queue, moves it.
  always_comb begin
    count_d        = count_q;
    tail_key_d     = tail_key_q;
    tail_payload_d = tail_payload_q;
    if (do_insert) begin
      count_d = count_q + 1'b1;
      if (empty || (tail_key_q < in_i.item_key)) begin
        tail_key_d     = in_i.item_key;
        tail_payload_d = in_i.item_payload;
      end
    end else if (do_remove) begin
      count_d = count_q - 1'b1;
    end
  end

  // Head after the step, taken from what slot zero is about to load.
  always_comb begin
    head_key_nxt     = cell_key[0];
    head_payload_nxt = cell_payload[0];
    if (do_insert && cell_ge[0]) begin
      head_key_nxt     = in_i.item_key;
      head_payload_nxt = in_i.item_payload;
    end else if (do_remove) begin
      head_key_nxt     = (DEPTH > 1) ? cell_key[DEPTH > 1 ? 1 : 0] : cell_key[0];
      head_payload_nxt = (DEPTH > 1) ? cell_payload[DEPTH > 1 ? 1 : 0] : cell_payload[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tail_key_q     <= tail_key_d;
    tail_payload_q <= tail_payload_d;
    if (xfer) begin
      rm_valid_q   <= do_remove;
      rm_key_q     <= do_remove ? cell_key[0] : '0;
      rm_payload_q <= do_remove ? cell_payload[0] : '0;
      overflow_q   <= (op == OP_INSERT) && full;
      res_count_q  <= count_d;
      if (count_d != '0) begin
        head_key_q         <= head_key_nxt;
        head_payload_q     <= head_payload_nxt;
        tail_key_res_q     <= tail_key_d;
        tail_payload_res_q <= tail_payload_d;
      end else begin
        head_key_q         <= '0;
        head_payload_q     <= '0;
        tail_key_res_q     <= '0;
        tail_payload_res_q <= '0;
      end
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.removed_valid   = rm_valid_q;
  assign out_o.removed_key     = rm_key_q;
  assign out_o.removed_payload = rm_payload_q;
  assign out_o.overflow        = overflow_q;
  assign out_o.entry_count     = CountFieldWidth'(res_count_q);
  assign out_o.head_key        = head_key_q;
  assign out_o.head_payload    = head_payload_q;
  assign out_o.tail_key        = tail_key_res_q;
  assign out_o.tail_payload    = tail_payload_res_q;

endmodule
